// ===== sv/wav_header_and_interleave_packer_core_defines.svh =====
// assertion macros shared by the wav packer rtl
// no dependencies; taken in by the files that carry checks
`ifndef WAV_HEADER_AND_INTERLEAVE_PACKER_CORE_DEFINES_SVH
`define WAV_HEADER_AND_INTERLEAVE_PACKER_CORE_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define WHIP_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("whip check failed");

// next-cycle implication, ignored while reset is high
`define WHIP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("whip check failed");

`endif

// ===== sv/whip_pkg.sv =====
// types, constants and header byte functions for the wav packer
// no dependencies; used by the top level, csr, queue, front and back files
package whip_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 5;

   localparam logic [5:0] HDR_LAST = 6'd43;

   localparam logic [2:0]  SB_RESET   = 3'd2;
   localparam logic [1:0]  EN_RESET   = 2'd3;
   localparam logic [29:0] SPC_RESET  = 30'd0;
   localparam logic [31:0] RATE_RESET = 32'd44100;

   localparam logic [15:0] FMT_PCM     = 16'h0001;
   localparam logic [15:0] FMT_FLOAT   = 16'h0003;
   localparam logic [31:0] FMT_CHUNK   = 32'd16;
   localparam logic [31:0] RIFF_BASE   = 32'd36;

   // tags, first character in the top byte
   localparam logic [31:0] TAG_RIFF = 32'h52494646;
   localparam logic [31:0] TAG_WAVE = 32'h57415645;
   localparam logic [31:0] TAG_FMT  = 32'h666d7420;
   localparam logic [31:0] TAG_DATA = 32'h64617461;

   typedef enum logic [2:0] {
      REG_SAMPLE_BYTES = 3'd0,
      REG_CHANNEL_EN   = 3'd1,
      REG_SAMPLES      = 3'd2,
      REG_SAMPLE_RATE  = 3'd3,
      REG_BIG_ENDIAN   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [2:0] sample_bytes;
      logic [1:0] channel_enable;
   } cfg_type;

   typedef struct packed {
      logic [31:0] riff_size;
      logic [15:0] fmt;
      logic [15:0] channels;
      logic [31:0] rate;
      logic [31:0] byte_rate;
      logic [15:0] align;
      logic [15:0] bits;
      logic [31:0] data_size;
      logic        big;
   } hdr_fields_type;

   typedef struct packed {
      logic        hdr;
      logic        has_a;
      logic        has_b;
      logic [1:0]  last_idx;
      logic [31:0] sample_a;
      logic [31:0] sample_b;
   } job_type;

   function automatic logic [7:0] tag_byte(logic [31:0] t, logic [1:0] k);
      logic [1:0] pos;
      pos = 2'd3 - k;
      return t[{pos, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] int4_byte(logic [31:0] v, logic [1:0] k, logic big);
      logic [1:0] pos;
      pos = big ? (2'd3 - k) : k;
      return v[{pos, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] int2_byte(logic [15:0] v, logic k, logic big);
      logic pos;
      pos = big ? ~k : k;
      return v[{pos, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] hdr_byte(logic [5:0] idx, hdr_fields_type f);
      logic [7:0] b;
      if (idx < 6'd4)       b = tag_byte(TAG_RIFF, idx[1:0]);
      else if (idx < 6'd8)  b = int4_byte(f.riff_size, idx[1:0], f.big);
      else if (idx < 6'd12) b = tag_byte(TAG_WAVE, idx[1:0]);
      else if (idx < 6'd16) b = tag_byte(TAG_FMT, idx[1:0]);
      else if (idx < 6'd20) b = int4_byte(FMT_CHUNK, idx[1:0], f.big);
      else if (idx < 6'd22) b = int2_byte(f.fmt, idx[0], f.big);
      else if (idx < 6'd24) b = int2_byte(f.channels, idx[0], f.big);
      else if (idx < 6'd28) b = int4_byte(f.rate, idx[1:0], f.big);
      else if (idx < 6'd32) b = int4_byte(f.byte_rate, idx[1:0], f.big);
      else if (idx < 6'd34) b = int2_byte(f.align, idx[0], f.big);
      else if (idx < 6'd36) b = int2_byte(f.bits, idx[0], f.big);
      else if (idx < 6'd40) b = tag_byte(TAG_DATA, idx[1:0]);
      else                  b = int4_byte(f.data_size, idx[1:0], f.big);
      return b;
   endfunction

endpackage

// ===== sv/whip_req_if.sv =====
// input channel of the wav packer: valid/ready plus command and sample pair
// no dependencies
interface whip_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] sample_a;
   logic [31:0] sample_b;

   modport source (output valid, command, sample_a, sample_b, input ready);
   modport sink   (input valid, command, sample_a, sample_b, output ready);
endinterface

// ===== sv/whip_rsp_if.sv =====
// result channel of the wav packer: one stream byte per beat
// no dependencies
interface whip_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_header;
   logic       last;

   modport source (output valid, out_byte, is_header, last, input ready);
   modport sink   (input valid, out_byte, is_header, last, output ready);
endinterface

// ===== sv/wav_header_and_interleave_packer_core.sv =====
// top level of the wav riff stream packer
// depends on whip_pkg, whip_req_if, whip_rsp_if, whip_csr, whip_front, whip_queue, whip_back
//
//   channel   kind        handshake                 payload
//   req_if    beat in     valid/ready               command, sample_a, sample_b
//   rsp_if    beat out    valid/ready               out_byte, is_header, last
//   csr_*     apb slave   psel/penable, pready = 1  5 registers at byte address 4*i
//
// an item that produces n output beats passes the back part in order: it first takes
// the job from the queue, then sends one byte per cycle, while the output is not
// stalled, through the single byte-wide output register (n is 44 for the header plus up to 8
// sample bytes). a rearm beat or a beat with nothing to send queues no job.
// reset is synchronous: header due, queue empty, registers at their defaults.
// the two-entry job queue lets the input keep accepting while the output stalls.
module wav_header_and_interleave_packer_core (
   input  logic                            clock,
   input  logic                            reset,
   whip_req_if.sink                        req_if,
   whip_rsp_if.source                      rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [whip_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   // live configuration and the registered header fields derived from it
   whip_pkg::cfg_type        cfg;
   whip_pkg::hdr_fields_type hdr_fields;

   // front to queue
   logic              q_push;
   logic              q_full;
   whip_pkg::job_type q_job;

   // queue to back
   logic              q_pop;
   logic              q_empty;
   whip_pkg::job_type q_head;

   // header arithmetic is one register behind the config registers; the first
   // header integer is read only after its job has left the queue and the riff tag bytes are loaded
   whip_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .hdr_fields  (hdr_fields)
   );

   // classify beats: rearm, sample pair with header and/or data, or nothing
   whip_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .cfg    (cfg),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (q_job)
   );

   // decouples acceptance from byte emission
   whip_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (q_head),
      .empty    (q_empty)
   );

   // byte sequencer: header, then channel a, then channel b
   whip_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .hdr_fields (hdr_fields),
      .rsp_if     (rsp_if)
   );

endmodule

// ===== sv/whip_csr.sv =====
// apb register file and registered header field arithmetic
// depends on whip_pkg
module whip_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [whip_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output whip_pkg::cfg_type               cfg,
   output whip_pkg::hdr_fields_type        hdr_fields
);

   logic [2:0]  sample_bytes_ff;
   logic [1:0]  channel_enable_ff;
   logic [29:0] samples_ff;
   logic [31:0] rate_ff;
   logic        big_ff;

   whip_pkg::csr_index_type     reg_idx;
   logic                        wr_en;
   logic [1:0]                  chan_cnt;
   logic [3:0]                  chan_bytes;
   logic [31:0]                 data_size;
   whip_pkg::hdr_fields_type    hdr_in;
   whip_pkg::hdr_fields_type    hdr_ff;

   assign reg_idx    = whip_pkg::csr_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_bytes_ff   <= whip_pkg::SB_RESET;
         channel_enable_ff <= whip_pkg::EN_RESET;
         samples_ff        <= whip_pkg::SPC_RESET;
         rate_ff           <= whip_pkg::RATE_RESET;
         big_ff            <= 1'b0;
      end else if (wr_en) begin
         case (reg_idx)
            whip_pkg::REG_SAMPLE_BYTES: sample_bytes_ff   <= csr_pwdata[2:0];
            whip_pkg::REG_CHANNEL_EN:   channel_enable_ff <= csr_pwdata[1:0];
            whip_pkg::REG_SAMPLES:      samples_ff        <= csr_pwdata[29:0];
            whip_pkg::REG_SAMPLE_RATE:  rate_ff           <= csr_pwdata;
            whip_pkg::REG_BIG_ENDIAN:   big_ff            <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         whip_pkg::REG_SAMPLE_BYTES: csr_prdata = {29'd0, sample_bytes_ff};
         whip_pkg::REG_CHANNEL_EN:   csr_prdata = {30'd0, channel_enable_ff};
         whip_pkg::REG_SAMPLES:      csr_prdata = {2'd0, samples_ff};
         whip_pkg::REG_SAMPLE_RATE:  csr_prdata = rate_ff;
         whip_pkg::REG_BIG_ENDIAN:   csr_prdata = {31'd0, big_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   // channels times bytes per sample fits four bits (at most 2 * 7)
   assign chan_cnt   = {1'b0, channel_enable_ff[0]} + {1'b0, channel_enable_ff[1]};
   assign chan_bytes = 4'(chan_cnt * sample_bytes_ff);
   assign data_size  = 32'({2'd0, samples_ff} * chan_bytes);

   always_comb begin
      hdr_in.riff_size = whip_pkg::RIFF_BASE + data_size;
      hdr_in.fmt       = (sample_bytes_ff == 3'd4) ? whip_pkg::FMT_FLOAT : whip_pkg::FMT_PCM;
      hdr_in.channels  = {14'd0, chan_cnt};
      hdr_in.rate      = rate_ff;
      hdr_in.byte_rate = 32'(rate_ff * chan_bytes);
      hdr_in.align     = {12'd0, chan_bytes};
      hdr_in.bits      = {10'd0, sample_bytes_ff, 3'b000};
      hdr_in.data_size = data_size;
      hdr_in.big       = big_ff;
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   assign cfg.sample_bytes   = sample_bytes_ff;
   assign cfg.channel_enable = channel_enable_ff;
   assign hdr_fields         = hdr_ff;

endmodule

// ===== sv/whip_queue.sv =====
// short job queue between the front and back parts
// depends on whip_pkg
module whip_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  whip_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output whip_pkg::job_type head_job,
   output logic              empty
);

   whip_pkg::job_type                   slot_ff [whip_pkg::QUEUE_DEPTH];
   logic [whip_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [whip_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [whip_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;

   localparam logic [whip_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      whip_pkg::QUEUE_PTR_W'(whip_pkg::QUEUE_DEPTH - 1);
   localparam logic [whip_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      whip_pkg::QUEUE_CNT_W'(whip_pkg::QUEUE_DEPTH);

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`include "wav_header_and_interleave_packer_core_defines.svh"

   `WHIP_ASSERT_NOW(a_no_push_full, clock, reset, full, !push || pop)
   `WHIP_ASSERT_NOW(a_no_pop_empty, clock, reset, empty, !pop)
   `WHIP_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== sv/whip_front.sv =====
// front part: accepts beats, tracks the pending header, queues jobs
// depends on whip_pkg, whip_req_if
module whip_front (
   input  logic              clock,
   input  logic              reset,
   whip_req_if.sink          req_if,
   input  whip_pkg::cfg_type cfg,
   input  logic              q_full,
   output logic              q_push,
   output whip_pkg::job_type q_job
);

   logic header_pending_ff, header_pending_in;
   logic accept;
   logic data_ok;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;

   assign data_ok = (cfg.sample_bytes == 3'd1) || (cfg.sample_bytes == 3'd2) ||
                    (cfg.sample_bytes == 3'd4);

   always_comb begin
      q_job.hdr      = header_pending_ff;
      q_job.has_a    = data_ok && cfg.channel_enable[0];
      q_job.has_b    = data_ok && cfg.channel_enable[1];
      q_job.last_idx = cfg.sample_bytes[1:0] - 2'd1;
      q_job.sample_a = req_if.sample_a;
      q_job.sample_b = req_if.sample_b;
   end

   // a sample beat with nothing to send queues nothing
   assign q_push = accept && !req_if.command && (q_job.hdr || q_job.has_a || q_job.has_b);

   always_comb begin
      header_pending_in = header_pending_ff;
      if (accept) begin
         if (req_if.command) begin
            header_pending_in = 1'b1;
         end else begin
            header_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_pending_ff <= 1'b1;
      end else begin
         header_pending_ff <= header_pending_in;
      end
   end

endmodule

// ===== sv/whip_back.sv =====
// back part: sequences header and sample bytes into the output register
// depends on whip_pkg, whip_rsp_if
module whip_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  whip_pkg::job_type        q_head,
   output logic                     q_pop,
   input  whip_pkg::hdr_fields_type hdr_fields,
   whip_rsp_if.source               rsp_if
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HDR,
      ST_CHA,
      ST_CHB
   } state_type;

   state_type         state_ff, state_in;
   state_type         after_end;
   whip_pkg::job_type job_ff;
   logic [5:0]        idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              is_header_ff, is_header_in;
   logic              last_ff, last_in;
   logic              load;
   logic              at_end;
   logic [7:0]        cur_byte;

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;
   assign load  = (state_ff != ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      case (state_ff)
         ST_HDR: begin
            cur_byte  = whip_pkg::hdr_byte(idx_ff, hdr_fields);
            at_end    = (idx_ff == whip_pkg::HDR_LAST);
            after_end = job_ff.has_a ? ST_CHA : (job_ff.has_b ? ST_CHB : ST_IDLE);
         end
         ST_CHA: begin
            cur_byte  = job_ff.sample_a[{idx_ff[1:0], 3'b000} +: 8];
            at_end    = (idx_ff[1:0] == job_ff.last_idx);
            after_end = job_ff.has_b ? ST_CHB : ST_IDLE;
         end
         ST_CHB: begin
            cur_byte  = job_ff.sample_b[{idx_ff[1:0], 3'b000} +: 8];
            at_end    = (idx_ff[1:0] == job_ff.last_idx);
            after_end = ST_IDLE;
         end
         default: begin
            cur_byte  = 8'd0;
            at_end    = 1'b0;
            after_end = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      byte_in      = byte_ff;
      is_header_in = is_header_ff;
      last_in      = last_ff;
      if (q_pop) begin
         idx_in   = 6'd0;
         state_in = q_head.hdr ? ST_HDR : (q_head.has_a ? ST_CHA : ST_CHB);
      end else if (load) begin
         rsp_valid_in = 1'b1;
         byte_in      = cur_byte;
         is_header_in = (state_ff == ST_HDR);
         last_in      = at_end && (after_end == ST_IDLE);
         if (at_end) begin
            state_in = after_end;
            idx_in   = 6'd0;
         end else begin
            idx_in = idx_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff      <= byte_in;
      is_header_ff <= is_header_in;
      last_ff      <= last_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_head;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_byte  = byte_ff;
   assign rsp_if.is_header = is_header_ff;
   assign rsp_if.last      = last_ff;

`include "wav_header_and_interleave_packer_core_defines.svh"

   `WHIP_ASSERT_NOW(a_idle_no_load, clock, reset, state_ff == ST_IDLE, !load)
   `WHIP_ASSERT_NEXT(a_last_ends_job, clock, reset, load && last_in, state_ff == ST_IDLE)

endmodule
